[src/lsrs_pkg.sv]
// lsrs_pkg: shared types and constants for the line sensor readout sequencer
// used by lsrs_cfg, lsrs_core and line_sensor_readout_sequencer; no dependencies

package lsrs_pkg;

	// default parameter values
	localparam int PIXELS_DEF      = 128;
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int TIMER_BITS_DEF  = 24;

	// fixed field widths
	localparam int CFG_W   = 24;
	localparam int IDX_W   = 7;
	localparam int VALUE_W = 12;
	localparam int CMP_W   = 32;
	localparam int EXT_W   = 32;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 4;

	// register reset values
	localparam logic [CFG_W-1:0] TRIGGER_HIGH_RST = 24'd960;
	localparam logic [CFG_W-1:0] CLOCK_HALF_RST   = 24'd1600;
	localparam logic [CFG_W-1:0] FRAME_GAP_RST    = 24'd16000;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_TRIGGER_HIGH = 2'd0;
	localparam logic [1:0] REG_CLOCK_HALF   = 2'd1;
	localparam logic [1:0] REG_FRAME_GAP    = 2'd2;

	typedef enum logic [2:0] {
		PH_WAIT    = 3'b001,
		PH_TRIGGER = 3'b010,
		PH_RUN     = 3'b100
	} seq_phase_t;

	typedef enum logic [2:0] {
		CK_LOW  = 3'b001,
		CK_RISE = 3'b010,
		CK_HIGH = 3'b100
	} ck_phase_t;

	typedef struct packed {
		logic [CFG_W-1:0] trigger_high_ticks;
		logic [CFG_W-1:0] clock_half_ticks;
		logic [CFG_W-1:0] frame_gap_ticks;
	} cfg_t;

	typedef struct packed {
		logic               frame_done;
		logic [VALUE_W-1:0] pixel_value;
		logic [IDX_W-1:0]   pixel_index;
		logic               pixel_valid;
		logic               clock_level;
		logic               trigger_level;
	} result_t;

endpackage

[src/lsrs_cfg.sv]
// lsrs_cfg: apb register file holding the three timing registers
// depends on lsrs_pkg

module lsrs_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lsrs_pkg::APB_AW-1:0]   paddr,
	input  logic [lsrs_pkg::APB_DW-1:0]   pwdata,
	output logic [lsrs_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output lsrs_pkg::cfg_t                cfg
);

	lsrs_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [1:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_high_ticks <= lsrs_pkg::TRIGGER_HIGH_RST;
			cfg_q.clock_half_ticks   <= lsrs_pkg::CLOCK_HALF_RST;
			cfg_q.frame_gap_ticks    <= lsrs_pkg::FRAME_GAP_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				lsrs_pkg::REG_TRIGGER_HIGH: cfg_q.trigger_high_ticks <= pwdata[lsrs_pkg::CFG_W-1:0];
				lsrs_pkg::REG_CLOCK_HALF:   cfg_q.clock_half_ticks   <= pwdata[lsrs_pkg::CFG_W-1:0];
				lsrs_pkg::REG_FRAME_GAP:    cfg_q.frame_gap_ticks    <= pwdata[lsrs_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			lsrs_pkg::REG_TRIGGER_HIGH: prdata = lsrs_pkg::APB_DW'(cfg_q.trigger_high_ticks);
			lsrs_pkg::REG_CLOCK_HALF:   prdata = lsrs_pkg::APB_DW'(cfg_q.clock_half_ticks);
			lsrs_pkg::REG_FRAME_GAP:    prdata = lsrs_pkg::APB_DW'(cfg_q.frame_gap_ticks);
			default:                    prdata = '0;
		endcase
	end

endmodule

[src/lsrs_core.sv]
// lsrs_core: frame sequencer state and its per-tick next-state logic
// depends on lsrs_pkg

module lsrs_core #(
	parameter int PIXELS      = lsrs_pkg::PIXELS_DEF,
	parameter int SAMPLE_BITS = lsrs_pkg::SAMPLE_BITS_DEF,
	parameter int TIMER_BITS  = lsrs_pkg::TIMER_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  lsrs_pkg::cfg_t         cfg,
	output lsrs_pkg::result_t      res
);

	localparam int PC_W = $clog2(PIXELS + 2);
	localparam logic [PC_W-1:0] PULSES = PC_W'(PIXELS + 1);

	lsrs_pkg::seq_phase_t seq_q, seq_n;
	lsrs_pkg::ck_phase_t  ck_q, ck_n;
	logic [PC_W-1:0]       pc_q, pc_n, pc_m1;
	logic [TIMER_BITS-1:0] te_q, te_n, ce_q, ce_n, ge_q, ge_n;
	logic                  tout_q, tout_n, cout_q, cout_n;
	logic                  valid, done;
	logic [lsrs_pkg::EXT_W-1:0] idx_ext, val_ext;

	function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// true when a counter strictly exceeds its register
	function automatic logic over(input logic [TIMER_BITS-1:0] cnt,
		input logic [lsrs_pkg::CFG_W-1:0] lim);
		return lsrs_pkg::CMP_W'(cnt) > lsrs_pkg::CMP_W'(lim);
	endfunction

	assign pc_m1   = pc_q - 1'b1;
	assign idx_ext = lsrs_pkg::EXT_W'(pc_m1);
	assign val_ext = lsrs_pkg::EXT_W'(sample);

	always_comb begin
		seq_n  = seq_q;
		ck_n   = ck_q;
		pc_n   = pc_q;
		tout_n = tout_q;
		cout_n = cout_q;
		valid  = 1'b0;
		done   = 1'b0;
		te_n   = sat_inc(te_q);
		ce_n   = sat_inc(ce_q);
		ge_n   = sat_inc(ge_q);

		if (seq_n == lsrs_pkg::PH_TRIGGER) begin
			tout_n = 1'b1;
			te_n   = '0;
			seq_n  = lsrs_pkg::PH_RUN;
		end
		if (over(te_n, cfg.trigger_high_ticks)) begin
			tout_n = 1'b0;
		end

		if (pc_q < PULSES) begin
			if (seq_n == lsrs_pkg::PH_RUN) begin
				unique case (ck_q)
					lsrs_pkg::CK_RISE: begin
						cout_n = 1'b1;
						ce_n   = '0;
						ck_n   = lsrs_pkg::CK_HIGH;
					end
					lsrs_pkg::CK_HIGH: begin
						// falling edge: sample taken here, the first pulse is a dummy
						if (over(ce_n, cfg.clock_half_ticks)) begin
							valid  = (pc_q != '0);
							cout_n = 1'b0;
							ce_n   = '0;
							ck_n   = lsrs_pkg::CK_LOW;
						end
					end
					lsrs_pkg::CK_LOW: begin
						if (over(ce_n, cfg.clock_half_ticks)) begin
							pc_n = pc_q + 1'b1;
							ck_n = lsrs_pkg::CK_RISE;
						end
					end
					default: ;
				endcase
			end
		end else begin
			if (seq_n == lsrs_pkg::PH_RUN) begin
				ge_n  = '0;
				seq_n = lsrs_pkg::PH_WAIT;
				done  = 1'b1;
				ck_n  = lsrs_pkg::CK_LOW;
			end
			tout_n = 1'b0;
			cout_n = 1'b0;
			if (over(ge_n, cfg.frame_gap_ticks)) begin
				pc_n  = '0;
				seq_n = lsrs_pkg::PH_TRIGGER;
				ck_n  = lsrs_pkg::CK_RISE;
			end
		end
	end

	always_comb begin
		res.trigger_level = tout_n;
		res.clock_level   = cout_n;
		res.pixel_valid   = valid;
		res.pixel_index   = valid ? idx_ext[lsrs_pkg::IDX_W-1:0] : '0;
		res.pixel_value   = valid ? val_ext[lsrs_pkg::VALUE_W-1:0] : '0;
		res.frame_done    = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q  <= lsrs_pkg::PH_TRIGGER;
			ck_q   <= lsrs_pkg::CK_RISE;
			pc_q   <= '0;
			te_q   <= '0;
			ce_q   <= '0;
			ge_q   <= '0;
			tout_q <= 1'b0;
			cout_q <= 1'b0;
		end else if (step) begin
			seq_q  <= seq_n;
			ck_q   <= ck_n;
			pc_q   <= pc_n;
			te_q   <= te_n;
			ce_q   <= ce_n;
			ge_q   <= ge_n;
			tout_q <= tout_n;
			cout_q <= cout_n;
		end
	end

endmodule

[src/line_sensor_readout_sequencer.sv]
// line_sensor_readout_sequencer: top level, stream ports, output register, apb port
// depends on lsrs_pkg, lsrs_cfg and lsrs_core
//
// channel   | signals                        | contents
// ----------+--------------------------------+------------------------------------------
// tick in   | s_tvalid s_tready s_tdata      | one timer tick with the converter sample
// result    | m_tvalid m_tready m_tdata      | pin levels and pixel, one per tick
//           | m_tuser m_tlast                | pixel_valid, frame_done
// config    | psel penable pwrite paddr      | timing registers at 0x0, 0x4, 0x8
//           | pwdata prdata pready           |
//
// each tick is one transfer; a new tick is taken every cycle while the output register can accept a result
// the state update and all counter compares sit between the sequencer state and
// the output register, so the result is registered and appears in the cycle after its tick
// reset starts a frame with the trigger pending and all counters at zero
// a stalled result holds in the output register; ticks are taken only while it can move

module line_sensor_readout_sequencer #(
	parameter int PIXELS      = lsrs_pkg::PIXELS_DEF,
	parameter int SAMPLE_BITS = lsrs_pkg::SAMPLE_BITS_DEF,
	parameter int TIMER_BITS  = lsrs_pkg::TIMER_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,  // adc_sample
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// trigger_level, clock_level, pixel_index, pixel_value, zero pad
	output logic [23:0]                          m_tdata,
	output logic                                 m_tuser,  // pixel_valid
	output logic                                 m_tlast,  // frame_done
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [lsrs_pkg::APB_AW-1:0]          paddr,
	input  logic [lsrs_pkg::APB_DW-1:0]          pwdata,
	output logic [lsrs_pkg::APB_DW-1:0]          prdata,
	output logic                                 pready
);

	lsrs_pkg::cfg_t    cfg;
	lsrs_pkg::result_t res, res_q;
	logic              m_tvalid_q;
	logic              in_xfer;

	assign s_tready = !m_tvalid_q || m_tready;
	assign in_xfer  = s_tvalid && s_tready;

	lsrs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lsrs_core #(
		.PIXELS      (PIXELS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.TIMER_BITS  (TIMER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (in_xfer),
		.sample (s_tdata[SAMPLE_BITS-1:0]),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (in_xfer) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, res_q.pixel_value, res_q.pixel_index,
		res_q.clock_level, res_q.trigger_level};
	assign m_tuser  = res_q.pixel_valid;
	assign m_tlast  = res_q.frame_done;

endmodule
